// ===== hw/rtl/csrch_pkg.sv =====
package csrch_pkg;

    localparam int CSRCH_TEXT_DEPTH    = 256;
    localparam int CSRCH_PATTERN_DEPTH = 64;

    typedef struct packed {
        logic clear;
        logic load;
        logic k_inc;
        logic k_zero;
        logic next_start;
        logic claim;
        logic out_load;
        logic out_found;
    } csrch_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic range_ok;
        logic match;
        logic k_last;
        logic out_free;
    } csrch_status_t;

endpackage

// ===== hw/rtl/csrch_ctrl.sv =====
module csrch_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_op,
    input  logic                    s_last,
    output logic                    s_ready,
    input  csrch_pkg::csrch_status_t status,
    output csrch_pkg::csrch_cmd_t    cmd
);
    import csrch_pkg::*;

    localparam logic [2:0] ST_CLEAR     = 3'd0;
    localparam logic [2:0] ST_IDLE      = 3'd1;
    localparam logic [2:0] ST_START     = 3'd2;
    localparam logic [2:0] ST_READ      = 3'd3;
    localparam logic [2:0] ST_COMPARE   = 3'd4;
    localparam logic [2:0] ST_CLAIM     = 3'd5;
    localparam logic [2:0] ST_DONE_MISS = 3'd6;
    localparam logic [2:0] ST_DONE_HIT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && s_op && s_last) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (status.range_ok) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_DONE_MISS;
                end
            end
            ST_READ: begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE: begin
                if (!status.match) begin
                    cmd.next_start = 1'b1;
                    state_next     = ST_START;
                end else if (status.k_last) begin
                    cmd.k_zero = 1'b1;
                    state_next = ST_CLAIM;
                end else begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_CLAIM: begin
                cmd.claim = 1'b1;
                cmd.k_inc = 1'b1;
                if (status.k_last) begin
                    state_next = ST_DONE_HIT;
                end
            end
            ST_DONE_MISS: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DONE_HIT: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_found = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/csrch_dp.sv =====
module csrch_dp #(
    parameter int TEXT_DEPTH    = csrch_pkg::CSRCH_TEXT_DEPTH,
    parameter int PATTERN_DEPTH = csrch_pkg::CSRCH_PATTERN_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_op,
    input  logic [7:0]               s_ch,
    input  logic                     s_last,
    input  csrch_pkg::csrch_cmd_t     cmd,
    output csrch_pkg::csrch_status_t  status,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_found,
    output logic [7:0]               m_position
);
    import csrch_pkg::*;

    localparam int TW  = $clog2(TEXT_DEPTH);
    localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int SW  = ((TW > PAW) ? TW : PAW) + 2;
    localparam logic [TW:0]  TD_V = (TW + 1)'(TEXT_DEPTH);
    localparam logic [PAW:0] PD_V = (PAW + 1)'(PATTERN_DEPTH);

    logic [7:0] text_mem  [TEXT_DEPTH];
    logic       claim_mem [TEXT_DEPTH];
    logic [7:0] pat_mem   [PATTERN_DEPTH];

    logic [TW:0]    text_len_reg;
    logic [TW:0]    text_widx_reg;
    logic [PAW:0]   pat_widx_reg;
    logic [PAW:0]   plen_reg;
    logic [TW:0]    start_reg;
    logic [PAW:0]   k_reg;
    logic [TW-1:0]  clr_addr_reg;
    logic [7:0]     text_rd_reg;
    logic [7:0]     pat_rd_reg;
    logic           claim_rd_reg;
    logic           out_valid_reg;
    logic           out_found_reg;
    logic [7:0]     out_pos_reg;

    logic           text_wr;
    logic           pat_wr;
    logic [TW:0]    text_widx_next;
    logic [PAW:0]   pat_widx_next;
    logic [SW-1:0]  span_end;
    logic [TW-1:0]  search_addr;
    logic           claim_we;
    logic [TW-1:0]  claim_waddr;
    logic           claim_wdata;

    assign text_wr = cmd.load && !s_op && (text_widx_reg < TD_V);
    assign pat_wr  = cmd.load && s_op && (pat_widx_reg < PD_V);
    assign text_widx_next = text_widx_reg + (TW + 1)'(text_widx_reg < TD_V);
    assign pat_widx_next  = pat_widx_reg + (PAW + 1)'(pat_widx_reg < PD_V);

    assign span_end    = SW'(start_reg) + SW'(plen_reg);
    assign search_addr = TW'(SW'(start_reg) + SW'(k_reg));

    always_comb begin
        claim_we    = 1'b0;
        claim_waddr = search_addr;
        claim_wdata = 1'b1;
        if (cmd.clear) begin
            claim_we    = 1'b1;
            claim_waddr = clr_addr_reg;
            claim_wdata = 1'b0;
        end else if (text_wr) begin
            claim_we    = 1'b1;
            claim_waddr = text_widx_reg[TW-1:0];
            claim_wdata = 1'b0;
        end else if (cmd.claim) begin
            claim_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (text_wr) begin
            text_mem[text_widx_reg[TW-1:0]] <= s_ch;
        end
        text_rd_reg <= text_mem[search_addr];
    end

    always_ff @(posedge aclk) begin
        if (claim_we) begin
            claim_mem[claim_waddr] <= claim_wdata;
        end
        claim_rd_reg <= claim_mem[search_addr];
    end

    always_ff @(posedge aclk) begin
        if (pat_wr) begin
            pat_mem[pat_widx_reg[PAW-1:0]] <= s_ch;
        end
        pat_rd_reg <= pat_mem[k_reg[PAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_len_reg  <= '0;
            text_widx_reg <= '0;
            pat_widx_reg  <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.load && !s_op) begin
                if (s_last) begin
                    text_len_reg  <= text_widx_next;
                    text_widx_reg <= '0;
                end else begin
                    text_widx_reg <= text_widx_next;
                end
            end
            if (cmd.load && s_op) begin
                if (s_last) begin
                    pat_widx_reg <= '0;
                end else begin
                    pat_widx_reg <= pat_widx_next;
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && s_op && s_last) begin
            plen_reg  <= pat_widx_next;
            start_reg <= '0;
            k_reg     <= '0;
        end else if (cmd.next_start) begin
            start_reg <= start_reg + 1'b1;
            k_reg     <= '0;
        end else if (cmd.k_zero) begin
            k_reg <= '0;
        end else if (cmd.k_inc) begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.out_load) begin
            out_found_reg <= cmd.out_found;
            out_pos_reg   <= cmd.out_found ? 8'(start_reg) : 8'd0;
        end
    end

    assign status.clear_done = (clr_addr_reg == TW'(TEXT_DEPTH - 1));
    assign status.range_ok   = (span_end <= SW'(text_len_reg));
    assign status.match      = (text_rd_reg == pat_rd_reg) && !claim_rd_reg;
    assign status.k_last     = ((k_reg + 1'b1) == plen_reg);
    assign status.out_free   = !out_valid_reg || m_ready;

    assign m_valid    = out_valid_reg;
    assign m_found    = out_found_reg;
    assign m_position = out_pos_reg;

endmodule

// ===== hw/rtl/claimed_substring_search.sv =====
// Claimed substring search over a stored text.
// Input channel (s_valid/s_ready): each transfer carries one character. With
// s_op low it is a text character; s_last on a text character ends the text and
// fixes its length. With s_op high it is a pattern character; s_last on a
// pattern character starts the search.
// Result channel (m_valid/m_ready): one transfer per completed pattern, giving
// m_found and the start index m_position of the first unclaimed match (zero
// when nothing is found). The matched span is then marked as claimed.
// A character transfer that starts no search is accepted while idle. A search
// then, for each start position tried, checks that the pattern fits in the
// text and reads and compares characters in turn (a memory read and a compare
// each) up to the first mismatch; on a hit it claims the pattern's characters
// one by one, and it ends by loading the result.
// After reset the claim marks are cleared in a pass over all TEXT_DEPTH
// entries, during which s_ready stays low.
// The result sits in an output register; characters keep being accepted while
// it waits, and a further search runs but holds s_ready low until it is free.
module claimed_substring_search #(
    parameter int TEXT_DEPTH    = csrch_pkg::CSRCH_TEXT_DEPTH,
    parameter int PATTERN_DEPTH = csrch_pkg::CSRCH_PATTERN_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_ch,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_found,
    output logic [7:0] m_position
);
    import csrch_pkg::*;

    csrch_cmd_t    cmd;
    csrch_status_t status;

    csrch_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_last  (s_last),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    csrch_dp #(
        .TEXT_DEPTH    (TEXT_DEPTH),
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_op       (s_op),
        .s_ch       (s_ch),
        .s_last     (s_last),
        .cmd        (cmd),
        .status     (status),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_found    (m_found),
        .m_position (m_position)
    );

    a_search_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op && s_last) |=> !s_ready)
        else $error("input accepted while a search is running");

    a_text_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_op) |=> !$rose(m_valid))
        else $error("result raised by a text transfer");

    a_miss_position_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_position == 8'd0))
        else $error("nonzero position on a result that found nothing");

endmodule
